@@ hdl/apm_pkg.sv @@
// Shared constants, types and register codes of the peak meter.
package apm_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 16;
	localparam int REG_BITS       = 16;
	localparam int PEAK_BITS      = 24;
	localparam int CFG_IDX_BITS   = 2;

	localparam int DC_BITS   = SAMPLE_BITS + COEF_FRAC_BITS;
	localparam int DIFF_BITS = DC_BITS + 1;
	localparam int MAG_BITS  = SAMPLE_BITS + 1;
	localparam int PROD_BITS = SAMPLE_BITS + 1 + REG_BITS + 1;
	localparam int SUM_BITS  = ((PROD_BITS > DC_BITS) ? PROD_BITS : DC_BITS) + 1;
	localparam int CMP_BITS  = (MAG_BITS > PEAK_BITS) ? MAG_BITS : PEAK_BITS;
	localparam int FALL_BITS = PEAK_BITS + REG_BITS;

	localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;

	localparam logic [REG_BITS-1:0] DC_COEF_RESET      = REG_BITS'(43);
	localparam logic [REG_BITS-1:0] HOLD_PERIODS_RESET = REG_BITS'(94);
	localparam logic [REG_BITS-1:0] FALL_MULT_RESET    = REG_BITS'(63570);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_DC_COEF      = 2'd0,
		CFG_HOLD_PERIODS = 2'd1,
		CFG_FALL_MULT    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [REG_BITS-1:0] dc_coef;
		logic [REG_BITS-1:0] hold_periods;
		logic [REG_BITS-1:0] fall_mult;
	} cfg_t;

endpackage

@@ hdl/apm_ifs.sv @@
// Handshake interfaces for the sample, peak and configuration channels.
interface apm_sample_if import apm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          end_of_period;

	modport source (output valid, output sample, output end_of_period, input ready);
	modport sink   (input valid, input sample, input end_of_period, output ready);
	modport mon    (input valid, input sample, input end_of_period, input ready);
endinterface

interface apm_peak_if import apm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PEAK_BITS-1:0] peak_level;

	modport source (output valid, output peak_level, input ready);
	modport sink   (input valid, input peak_level, output ready);
	modport mon    (input valid, input peak_level, input ready);
endinterface

interface apm_cfg_if import apm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [REG_BITS-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
	modport mon    (input valid, input index, input data, input ready);
endinterface

@@ hdl/apm_dc_filter.sv @@
// One-pole DC tracking filter: holds the estimate and gives the DC-free difference.
module apm_dc_filter import apm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic        [REG_BITS-1:0]    dc_coef,
	output logic signed [DIFF_BITS-1:0]   diff_out
);

	logic signed [DC_BITS-1:0]             dc_q;
	logic signed [DC_BITS-1:0]             scaled;
	logic signed [DIFF_BITS-1:0]           diff;
	logic signed [MAG_BITS-1:0]            diff_hi;
	logic        [COEF_FRAC_BITS-1:0]      diff_lo;
	logic signed [REG_BITS:0]              coef_s;
	logic signed [PROD_BITS-1:0]           prod_hi;
	logic [COEF_FRAC_BITS+REG_BITS-1:0]    prod_lo;
	logic        [REG_BITS-1:0]            lo_term;
	logic signed [SUM_BITS-1:0]            dc_sum;
	logic signed [DC_BITS-1:0]             dc_next;

	assign scaled  = {sample, {COEF_FRAC_BITS{1'b0}}};
	assign diff    = DIFF_BITS'(scaled) - DIFF_BITS'(dc_q);
	assign diff_hi = diff[DIFF_BITS-1:COEF_FRAC_BITS];
	assign diff_lo = diff[COEF_FRAC_BITS-1:0];
	assign coef_s  = $signed({1'b0, dc_coef});
	assign prod_hi = PROD_BITS'(diff_hi) * PROD_BITS'(coef_s);
	assign prod_lo = (COEF_FRAC_BITS + REG_BITS)'(diff_lo) * (COEF_FRAC_BITS + REG_BITS)'(dc_coef);
	assign lo_term = prod_lo[COEF_FRAC_BITS+REG_BITS-1:COEF_FRAC_BITS];
	assign dc_sum  = SUM_BITS'(dc_q) + SUM_BITS'(prod_hi) + SUM_BITS'($signed({1'b0, lo_term}));
	assign dc_next = dc_sum[DC_BITS-1:0];

	assign diff_out = DIFF_BITS'(scaled) - DIFF_BITS'(dc_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
		end else if (en) begin
			dc_q <= dc_next;
		end
	end

endmodule

@@ hdl/apm_peak_hold.sv @@
// Period maximum, held peak, hold counter and falloff.
module apm_peak_hold import apm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [PEAK_BITS-1:0] mag,
	input  logic                 eop,
	input  cfg_t                 cfg,
	output logic [PEAK_BITS-1:0] peak_next
);

	logic [PEAK_BITS-1:0] period_max_q;
	logic [PEAK_BITS-1:0] held_peak_q;
	logic [REG_BITS-1:0]  hold_count_q;
	logic [PEAK_BITS-1:0] pm_cur;
	logic [FALL_BITS-1:0] fall_prod;
	logic [FALL_BITS-1:0] fall_sh;
	logic [PEAK_BITS-1:0] fall_val;
	logic [REG_BITS-1:0]  count_next;

	assign pm_cur    = (mag > period_max_q) ? mag : period_max_q;
	assign fall_prod = FALL_BITS'(held_peak_q) * FALL_BITS'(cfg.fall_mult);
	assign fall_sh   = fall_prod >> COEF_FRAC_BITS;
	assign fall_val  = (fall_sh > FALL_BITS'(PEAK_MAX)) ? PEAK_MAX : fall_sh[PEAK_BITS-1:0];

	always_comb begin
		peak_next  = held_peak_q;
		count_next = hold_count_q;
		if (pm_cur > held_peak_q) begin
			peak_next  = pm_cur;
			count_next = cfg.hold_periods;
		end else if (hold_count_q != '0) begin
			count_next = hold_count_q - 1'b1;
		end else begin
			peak_next = fall_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_max_q <= '0;
			held_peak_q  <= '0;
			hold_count_q <= '0;
		end else if (en) begin
			if (eop) begin
				period_max_q <= '0;
				held_peak_q  <= peak_next;
				hold_count_q <= count_next;
			end else begin
				period_max_q <= pm_cur;
			end
		end
	end

endmodule

@@ hdl/audio_peak_meter_hold_fall.sv @@
// Top level of the peak meter with hold and falloff.
//
//  channel   role  word
//  samples   sink  sample (signed 24), end_of_period
//  peaks     src   peak_level (unsigned 24), one word per period end
//  cfg       sink  index (2), data (16): dc_coef, hold_periods, fall_mult
//
// One sample per cycle when nothing stalls; the DC estimate loop
// (subtract, multiply, add) sets that rate. Period ends go via s1, s2, s3 to peak_q.
// Reset clears the DC estimate, period max, held peak, hold count and all valids;
// registers return to their defaults. No clearing pass.
// A stalled peak word holds; samples keep entering until the three stages fill.
module audio_peak_meter_hold_fall import apm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	apm_sample_if.sink  samples,
	apm_peak_if.source  peaks,
	apm_cfg_if.sink     cfg
);

	cfg_t                          cfg_q;
	logic                          v_s1, v_s2, v_s3;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          eop_s1, eop_s2, eop_s3;
	logic signed [DIFF_BITS-1:0]   diff_s2;
	logic        [PEAK_BITS-1:0]   mag_s3;
	logic                          out_valid_q;
	logic        [PEAK_BITS-1:0]   peak_q;

	logic                          out_free, go3, rdy3, rdy2, rdy1, mv1, mv2, take;
	logic signed [DIFF_BITS-1:0]   diff_w;
	logic signed [MAG_BITS-1:0]    y_w;
	logic        [MAG_BITS-1:0]    abs_w;
	logic        [CMP_BITS-1:0]    abs_c;
	logic        [PEAK_BITS-1:0]   mag_w;
	logic        [PEAK_BITS-1:0]   peak_next;

	assign out_free = !out_valid_q || peaks.ready;
	assign go3      = v_s3 && (!eop_s3 || out_free);
	assign rdy3     = !v_s3 || go3;
	assign rdy2     = !v_s2 || rdy3;
	assign mv2      = v_s2 && rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign mv1      = v_s1 && rdy2;
	assign take     = samples.valid && rdy1;

	assign samples.ready    = rdy1;
	assign peaks.valid      = out_valid_q;
	assign peaks.peak_level = peak_q;
	assign cfg.ready        = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_coef      <= DC_COEF_RESET;
			cfg_q.hold_periods <= HOLD_PERIODS_RESET;
			cfg_q.fall_mult    <= FALL_MULT_RESET;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_DC_COEF:      cfg_q.dc_coef      <= cfg.data;
				CFG_HOLD_PERIODS: cfg_q.hold_periods <= cfg.data;
				CFG_FALL_MULT:    cfg_q.fall_mult    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	apm_dc_filter u_dc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (mv1),
		.sample   (sample_s1),
		.dc_coef  (cfg_q.dc_coef),
		.diff_out (diff_w)
	);

	assign y_w   = diff_s2[DIFF_BITS-1:COEF_FRAC_BITS];
	assign abs_w = y_w[MAG_BITS-1] ? MAG_BITS'(-y_w) : MAG_BITS'(y_w);
	assign abs_c = CMP_BITS'(abs_w);
	assign mag_w = (abs_c > CMP_BITS'(PEAK_MAX)) ? PEAK_MAX : abs_c[PEAK_BITS-1:0];

	apm_peak_hold u_hold (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (go3),
		.mag       (mag_s3),
		.eop       (eop_s3),
		.cfg       (cfg_q),
		.peak_next (peak_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= samples.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (go3 && eop_s3) begin
				out_valid_q <= 1'b1;
			end else if (peaks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= samples.sample;
			eop_s1    <= samples.end_of_period;
		end
		if (mv1) begin
			diff_s2 <= diff_w;
			eop_s2  <= eop_s1;
		end
		if (mv2) begin
			mag_s3 <= mag_w;
			eop_s3 <= eop_s2;
		end
		if (go3 && eop_s3) begin
			peak_q <= peak_next;
		end
	end

endmodule

@@ hdl/apm_checker.sv @@
// Port-level checks of the peak meter, bound to the top level.
module apm_checker import apm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_ready,
	input logic                 peak_valid,
	input logic                 peak_ready,
	input logic [PEAK_BITS-1:0] peak_level
);

	a_peak_held: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid && !peak_ready |=> peak_valid)
		else $error("peak word dropped while stalled");

	a_level_stable: assert property (@(posedge clk) disable iff (!arst_n)
		peak_valid && !peak_ready |=> $stable(peak_level))
		else $error("peak level changed while stalled");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !peak_valid)
		else $error("peak word shown during reset");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!peak_valid |-> sample_ready)
		else $error("samples refused with empty output");

endmodule

bind audio_peak_meter_hold_fall apm_checker u_apm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (samples.ready),
	.peak_valid   (peaks.valid),
	.peak_ready   (peaks.ready),
	.peak_level   (peaks.peak_level)
);

@@ dv/tb_audio_peak_meter_hold_fall.sv @@
// Self-checking testbench of the peak meter: directed and random samples under several register settings.
module tb_audio_peak_meter_hold_fall;
	timeunit 1ns;
	timeprecision 1ps;
	import apm_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = CFG_IDX_BITS'(3);
	localparam logic [REG_BITS-1:0] REG_TOP = '1;
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_OFF_LEN  = 300;
	localparam int RANDOM_BLOCKS = 6;
	localparam int BLOCK_WORDS   = 128;

	class peak_ledger;
		logic [REG_BITS-1:0]  dc_coef, hold_periods, fall_mult;
		longint               dc_est;
		logic [PEAK_BITS-1:0] period_max, held_peak;
		logic [REG_BITS-1:0]  hold_count;
		logic [PEAK_BITS-1:0] peaks_due[$];
		int                   errors, samples_taken, peaks_matched;

		function new();
			dc_coef       = DC_COEF_RESET;
			hold_periods  = HOLD_PERIODS_RESET;
			fall_mult     = FALL_MULT_RESET;
			dc_est        = 0;
			period_max    = '0;
			held_peak     = '0;
			hold_count    = '0;
			errors        = 0;
			samples_taken = 0;
			peaks_matched = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] d);
			case (idx)
				CFG_DC_COEF:      dc_coef = d;
				CFG_HOLD_PERIODS: hold_periods = d;
				CFG_FALL_MULT:    fall_mult = d;
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [SAMPLE_BITS-1:0] s, logic eop);
			longint               scaled, y, mag;
			logic [FALL_BITS-1:0] shrunk;
			samples_taken++;
			scaled = longint'(s) <<< COEF_FRAC_BITS;
			dc_est += ((scaled - dc_est) * longint'(dc_coef)) >>> COEF_FRAC_BITS;
			y = (scaled - dc_est) >>> COEF_FRAC_BITS;
			mag = (y < 0) ? -y : y;
			if (mag > longint'(PEAK_MAX))
				mag = longint'(PEAK_MAX);
			if (mag > longint'(period_max))
				period_max = PEAK_BITS'(mag);
			if (!eop)
				return;
			if (period_max > held_peak) begin
				held_peak  = period_max;
				hold_count = hold_periods;
			end else if (hold_count != 0) begin
				hold_count--;
			end else begin
				shrunk    = held_peak * fall_mult;
				held_peak = shrunk[FALL_BITS-1:COEF_FRAC_BITS];
			end
			period_max = '0;
			peaks_due.push_back(held_peak);
		endfunction

		function void match_peak(logic [PEAK_BITS-1:0] got);
			logic [PEAK_BITS-1:0] want;
			if (peaks_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected peak_level word, expected none, got %0d", $time, got);
				return;
			end
			want = peaks_due.pop_front();
			peaks_matched++;
			if (got !== want) begin
				errors++;
				$display("%0t: peak_level mismatch, expected %0d, got %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return peaks_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	apm_sample_if sample_ch();
	apm_peak_if   peak_ch();
	apm_cfg_if    cfg_ch();

	audio_peak_meter_hold_fall uut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.peaks  (peak_ch),
		.cfg    (cfg_ch)
	);

	peak_ledger ledger = new();

	int gap_pct     = 37;
	int stall_pct   = 53;
	int hold_reqs   = 0;
	int quiet_cycles = 0;
	int words_sent  = 0;
	int reg_writes  = 0;
	int dc_offset   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int holds_taken;
		int hold_left;
		holds_taken = 0;
		hold_left = 0;
		peak_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_taken) begin
				holds_taken = hold_reqs;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				peak_ch.ready <= 1'b0;
			end else begin
				peak_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				ledger.take_sample(sample_ch.sample, sample_ch.end_of_period);
			if (peak_ch.valid && peak_ch.ready)
				ledger.match_peak(peak_ch.peak_level);
			if (cfg_ch.valid && cfg_ch.ready) begin
				ledger.write_reg(cfg_ch.index, cfg_ch.data);
				reg_writes++;
			end
			if ((sample_ch.valid && sample_ch.ready) || (peak_ch.valid && peak_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no handshake for %0d cycles, %0d peak words outstanding", $time,
			QUIET_LIMIT, ledger.pending());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		int v;
		case ($urandom_range(9))
			0, 1:    v = $signed($urandom()) >>> (32 - SAMPLE_BITS);
			2:       v = $urandom_range(1) ? int'(SAMPLE_TOP) : int'(SAMPLE_BOTTOM);
			3, 4:    v = int'($urandom_range(64)) - 32;
			default: v = dc_offset + int'($urandom_range(4096)) - 2048;
		endcase
		if (v > SAMPLE_TOP)
			v = int'(SAMPLE_TOP);
		if (v < SAMPLE_BOTTOM)
			v = int'(SAMPLE_BOTTOM);
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input logic eop);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.sample        <= s;
		sample_ch.end_of_period <= eop;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_period(input int len);
		for (int k = 0; k < len; k++)
			send_word(pick_sample(), k == len - 1);
	endtask

	// drop valid, wait for every peak word, then let the pipeline empty
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [REG_BITS-1:0] dc, input logic [REG_BITS-1:0] hold,
			input logic [REG_BITS-1:0] fall);
		drain();
		write_reg(CFG_DC_COEF, dc);
		write_reg(CFG_HOLD_PERIODS, hold);
		write_reg(CFG_FALL_MULT, fall);
	endtask

	initial begin
		int  first;
		int  len;
		bit  held_off;
		arst_n                  = 1'b0;
		sample_ch.valid         = 1'b0;
		sample_ch.sample        = '0;
		sample_ch.end_of_period = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = CFG_DC_COEF;
		cfg_ch.data             = '0;
		held_off                = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word('0, 1'b0);
		send_word('0, 1'b1);

		// no DC tracking, short hold, halving fall
		set_regs(16'd0, 16'd1, 16'd32768);
		write_reg(CFG_UNUSED, REG_BITS'($urandom()));
		send_word(SAMPLE_BITS'(1000), 1'b0);
		send_word(SAMPLE_BITS'(-600), 1'b1);
		send_word(SAMPLE_BITS'(-1000), 1'b1);
		send_word(SAMPLE_BITS'(1000), 1'b1);
		send_word(SAMPLE_BITS'(200), 1'b0);
		send_word(SAMPLE_BITS'(-300), 1'b1);
		send_word(SAMPLE_TOP, 1'b1);
		send_word(SAMPLE_BOTTOM, 1'b1);
		send_word('0, 1'b1);
		send_word('0, 1'b1);

		set_regs(DC_COEF_RESET, HOLD_PERIODS_RESET, FALL_MULT_RESET);
		send_word(SAMPLE_TOP, 1'b0);
		send_word(SAMPLE_BOTTOM, 1'b1);
		send_word(SAMPLE_BITS'(-1), 1'b1);
		send_word(SAMPLE_BITS'(1), 1'b1);

		// fast tracking with full-scale swings: the estimate follows each sample closely, so the magnitude stays small
		set_regs(REG_TOP, 16'd0, REG_TOP);
		repeat (4) send_word(SAMPLE_TOP, 1'b0);
		send_word(SAMPLE_BOTTOM, 1'b1);
		repeat (3) send_word(SAMPLE_BOTTOM, 1'b0);
		send_word(SAMPLE_TOP, 1'b1);

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			case (b)
				0:       set_regs(REG_TOP, 16'd0, 16'd0);
				1:       set_regs(16'd1, REG_TOP, REG_TOP);
				2:       set_regs(REG_BITS'($urandom()), REG_BITS'($urandom_range(4)),
						REG_BITS'($urandom()));
				3:       set_regs(16'd0, 16'd0, REG_TOP);
				4:       set_regs(REG_BITS'($urandom_range(4096)), REG_BITS'($urandom_range(2)),
						REG_BITS'($urandom_range(32768, 65535)));
				default: set_regs(DC_COEF_RESET, HOLD_PERIODS_RESET, FALL_MULT_RESET);
			endcase
			if (b == 2)
				write_reg(CFG_UNUSED, REG_BITS'($urandom()));
			gap_pct   = (b < 2) ? 37 : (b < 4) ? 53 : 0;
			stall_pct = (b < 2) ? 53 : (b < 4) ? 37 : 0;
			first = words_sent;
			while (words_sent - first < BLOCK_WORDS) begin
				if (b == 4 && !held_off && words_sent - first >= 40) begin
					held_off = 1'b1;
					hold_reqs <= hold_reqs + 1;
					repeat (30) send_word(pick_sample(), 1'b1);
				end
				if ($urandom_range(7) == 0)
					dc_offset = $signed($urandom()) >>> (32 - SAMPLE_BITS);
				len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
				send_period(len);
			end
		end

		drain();
		$display("Sent %0d samples, checked %0d peak words, made %0d register writes",
			ledger.samples_taken, ledger.peaks_matched, reg_writes);
		$display("Settings included zero and full-scale coefficients, hold and fall factors");
		if (ledger.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
